// ----- hw/rtl/sabtb_pkg.sv -----
// Shared types, geometry constants and replacement helpers for the branch target buffer.
// Depends on nothing; every other file in hw/rtl but sabtb_ram imports it.
package sabtb_pkg;

    localparam int SETS  = 64;
    localparam int WAYS  = 4;

    // Set count is kept a power of two: the index is a plain slice of the pc
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = $clog2(WAYS);
    localparam int PLRU_W = (1 << WAY_W) - 1;
    localparam int NODE_W = WAY_W + 1;

    localparam logic [15:0] LFSR_RESET = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;

    // ceil(2^32 / WAYS): exact quotient for any 16-bit dividend
    localparam longint unsigned VIC_RECIP_L =
        ((64'd1 << 32) + 64'(WAYS) - 64'd1) / 64'(WAYS);
    localparam logic [32:0] VIC_RECIP = 33'(VIC_RECIP_L);

    localparam logic [1:0] KIND_PROBE  = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_UPDATE = 2'd2;
    localparam logic [1:0] KIND_FLUSH  = 2'd3;

    typedef logic [SET_W-1:0]  t_set_idx;
    typedef logic [WAY_W-1:0]  t_way_idx;
    typedef logic [PLRU_W-1:0] t_plru;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] branch_pc;
        logic [63:0] branch_target;
        logic [3:0]  entry_type;
    } t_cmd;

    typedef struct packed {
        logic        hit;
        logic [63:0] hit_target;
        logic [3:0]  hit_type;
    } t_res;

    typedef struct packed {
        logic [63:0] tag;
        logic [63:0] target;
        logic [3:0]  etype;
    } t_way_ent;

    typedef t_way_ent [WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    typedef struct packed {
        logic     hit;
        t_way_idx way;
    } t_match;

    typedef struct packed {
        logic rnd;
        logic step;
    } t_evict_req;

    // Walk the tree: a set node bit sends the walk to the lower half
    function automatic t_way_idx plru_victim(input t_plru bits);
        logic [WAY_W:0]    lo;
        logic [WAY_W:0]    hi;
        logic [WAY_W:0]    mid;
        logic [NODE_W-1:0] node;
        t_plru             sh;
        lo   = '0;
        hi   = (WAY_W + 1)'(WAYS - 1);
        node = '0;
        for (int i = 0; i < WAY_W; i++) begin
            if (lo < hi) begin
                mid = (lo + hi) >> 1;
                sh  = bits >> node;
                if (sh[0]) begin
                    hi   = mid;
                    node = (node << 1) + NODE_W'(1);
                end else begin
                    lo   = mid + (WAY_W + 1)'(1);
                    node = (node << 1) + NODE_W'(2);
                end
            end
        end
        return lo[WAY_W-1:0];
    endfunction

    // Point every node on the path of the way away from it
    function automatic t_plru plru_touch(input t_plru bits, input t_way_idx way);
        logic [WAY_W:0]    lo;
        logic [WAY_W:0]    hi;
        logic [WAY_W:0]    mid;
        logic [NODE_W-1:0] node;
        t_plru             res;
        lo   = '0;
        hi   = (WAY_W + 1)'(WAYS - 1);
        node = '0;
        res  = bits;
        for (int i = 0; i < WAY_W; i++) begin
            if (lo < hi) begin
                mid = (lo + hi) >> 1;
                if ({1'b0, way} <= mid) begin
                    res  = res & ~(PLRU_W'(1) << node);
                    hi   = mid;
                    node = (node << 1) + NODE_W'(1);
                end else begin
                    res  = res | (PLRU_W'(1) << node);
                    lo   = mid + (WAY_W + 1)'(1);
                    node = (node << 1) + NODE_W'(2);
                end
            end
        end
        return res;
    endfunction

    function automatic logic [15:0] lfsr_step(input logic [15:0] v);
        logic [15:0] n;
        n = v >> 1;
        if (v[0]) begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

endpackage

// ----- hw/rtl/sabtb_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Stand-alone; used for the entry store and the replacement bits.
module sabtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/sabtb_match.sv -----
// Parallel tag compare across all ways of one set, lowest matching way wins.
// Depends on sabtb_pkg.
module sabtb_match (
    input  sabtb_pkg::t_row   i_row,
    input  logic [63:0]       i_pc,
    output sabtb_pkg::t_match o_match
);
    import sabtb_pkg::*;

    always_comb begin
        o_match = '0;
        // scan downwards so the lowest hit is left standing
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (i_row[w].tag == i_pc) begin
                o_match.hit = 1'b1;
                o_match.way = t_way_idx'(w);
            end
        end
    end

endmodule

// ----- hw/rtl/sabtb_evict.sv -----
// Victim selection: tree pseudo-LRU walk or the 16-bit Galois LFSR reduced modulo the ways.
// Depends on sabtb_pkg.
module sabtb_evict (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sabtb_pkg::t_evict_req i_req,
    input  sabtb_pkg::t_plru      i_plru,
    output sabtb_pkg::t_way_idx   o_victim
);
    import sabtb_pkg::*;

    logic [15:0] r_lfsr;
    logic [15:0] r_lfsr_nxt;
    logic [15:0] r_vic_q;
    logic [15:0] n_lfsr_nxt;
    logic [48:0] quot_prod;
    logic [15:0] qw;
    logic [15:0] rem;

    // Precompute the stepped value and its quotient; r_lfsr only moves on a random add
    assign n_lfsr_nxt = lfsr_step(r_lfsr);
    assign quot_prod  = {33'd0, n_lfsr_nxt} * {16'd0, VIC_RECIP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= LFSR_RESET;
        end else if (i_req.step) begin
            r_lfsr <= r_lfsr_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lfsr_nxt <= n_lfsr_nxt;
        r_vic_q    <= quot_prod[47:32];
    end

    assign qw  = 16'(r_vic_q * 16'(WAYS));
    assign rem = r_lfsr_nxt - qw;

    assign o_victim = i_req.rnd ? rem[WAY_W-1:0] : plru_victim(i_plru);

endmodule

// ----- hw/rtl/set_assoc_branch_target_buffer.sv -----
// Top level of the set-associative branch target buffer.
// Depends on sabtb_pkg, sabtb_ram, sabtb_match and sabtb_evict.
//
// Usage:
//   Command channel: drive i_cmd and raise i_start; the transaction is taken
//   at a clock edge where i_start is high and o_busy is low. Kinds are probe,
//   add, update and flush of the whole buffer.
//   Result channel: every command gives exactly one result on o_res, shown
//   for one cycle with o_res_valid high. The receiver cannot hold it off.
//   Configuration: i_cfg_valid / o_cfg_ready write evict_mode (bit 0 of
//   i_cfg_data); o_cfg_ready is always high. Write it only while idle.
// Timing:
//   A command first reads the set row and the replacement bits from the
//   synchronous RAMs, then compares, chooses and writes back. o_busy is
//   high during the compare step, so no new command is accepted while one
//   is being compared; the result is registered at the end of the compare
//   step and is then shown with o_res_valid high.
// Reset:
//   Per-set valid bits in flops make all entries and tree bits read as zero
//   right after reset; no clearing pass is needed. A flush clears those bits
//   at write-back. The LFSR resets to 16'hACE1 and is kept across a flush.
module set_assoc_branch_target_buffer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  sabtb_pkg::t_cmd i_cmd,
    output logic            o_res_valid,
    output sabtb_pkg::t_res o_res,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_data
);
    import sabtb_pkg::*;

    logic          r_busy;
    t_cmd          r_cmd;
    t_set_idx      r_set;
    logic          r_row_vld_q;
    logic          r_plru_vld_q;
    logic [SETS-1:0] r_row_vld;
    logic [SETS-1:0] r_plru_vld;
    logic [SETS-1:0] n_row_vld;
    logic [SETS-1:0] n_plru_vld;
    logic          r_evict_mode;
    logic          r_res_vld;
    t_res          r_res;
    t_res          n_res;

    logic          accept;
    t_set_idx      rd_set;
    logic [ROW_W-1:0]  row_rdata;
    t_plru         plru_rdata;
    t_row          row_q;
    t_plru         plru_q;
    t_row          row_wd;
    t_plru         plru_wd;
    logic          row_we;
    logic          plru_we;
    logic          flush;
    t_match        mt;
    t_evict_req    ev_req;
    t_way_idx      victim;

    assign accept = i_start && !r_busy;
    assign rd_set = i_cmd.branch_pc[SET_W:1];

    sabtb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_set),
        .i_wdata (ROW_W'(row_wd)),
        .i_re    (accept),
        .i_raddr (rd_set),
        .o_rdata (row_rdata)
    );

    sabtb_ram #(
        .WIDTH (PLRU_W),
        .DEPTH (SETS)
    ) u_plru_ram (
        .i_clk   (i_clk),
        .i_we    (plru_we),
        .i_waddr (r_set),
        .i_wdata (plru_wd),
        .i_re    (accept),
        .i_raddr (rd_set),
        .o_rdata (plru_rdata)
    );

    // Rows not written since reset or flush read as zero
    assign row_q  = r_row_vld_q  ? t_row'(row_rdata) : '0;
    assign plru_q = r_plru_vld_q ? plru_rdata : '0;

    sabtb_match u_match (
        .i_row   (row_q),
        .i_pc    (r_cmd.branch_pc),
        .o_match (mt)
    );

    sabtb_evict u_evict (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (ev_req),
        .i_plru   (plru_q),
        .o_victim (victim)
    );

    always_comb begin
        n_res       = '0;
        row_we      = 1'b0;
        row_wd      = row_q;
        plru_we     = 1'b0;
        plru_wd     = plru_q;
        flush       = 1'b0;
        ev_req.rnd  = r_evict_mode;
        ev_req.step = 1'b0;
        if (r_busy) begin
            case (r_cmd.kind)
                KIND_PROBE: begin
                    if (mt.hit) begin
                        n_res.hit        = 1'b1;
                        n_res.hit_target = row_q[mt.way].target;
                        n_res.hit_type   = row_q[mt.way].etype;
                        if (!r_evict_mode) begin
                            plru_we = 1'b1;
                            plru_wd = plru_touch(plru_q, mt.way);
                        end
                    end
                end
                KIND_ADD: begin
                    row_we                = 1'b1;
                    row_wd[victim].tag    = r_cmd.branch_pc;
                    row_wd[victim].target = '0;
                    row_wd[victim].etype  = r_cmd.entry_type;
                    ev_req.step           = r_evict_mode;
                end
                KIND_UPDATE: begin
                    if (mt.hit) begin
                        row_we                = 1'b1;
                        row_wd[mt.way].target = r_cmd.branch_target;
                        row_wd[mt.way].etype  = r_cmd.entry_type;
                        n_res.hit             = 1'b1;
                        n_res.hit_target      = r_cmd.branch_target;
                        n_res.hit_type        = r_cmd.entry_type;
                    end
                end
                KIND_FLUSH: begin
                    flush = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_row_vld  = r_row_vld;
        n_plru_vld = r_plru_vld;
        if (flush) begin
            n_row_vld  = '0;
            n_plru_vld = '0;
        end else begin
            if (row_we) begin
                n_row_vld[r_set] = 1'b1;
            end
            if (plru_we) begin
                n_plru_vld[r_set] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_row_vld    <= '0;
            r_plru_vld   <= '0;
            r_evict_mode <= 1'b0;
            r_res_vld    <= 1'b0;
        end else begin
            r_busy     <= accept;
            r_row_vld  <= n_row_vld;
            r_plru_vld <= n_plru_vld;
            r_res_vld  <= r_busy;
            if (i_cfg_valid && o_cfg_ready) begin
                r_evict_mode <= i_cfg_data;
            end
        end
    end

    // Hold the command and the valid bits of its set for the compare cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd        <= i_cmd;
            r_set        <= rd_set;
            r_row_vld_q  <= r_row_vld[rd_set];
            r_plru_vld_q <= r_plru_vld[rd_set];
        end
        r_res <= n_res;
    end

    assign o_busy      = r_busy;
    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- tb/btb_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the branch target buffer: mirrors tags, targets, types, tree bits and LFSR.
// Watches the command, result and configuration channels; depends on sabtb_pkg.
module btb_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            o_busy,
    input  sabtb_pkg::t_cmd i_cmd,
    input  logic            o_res_valid,
    input  sabtb_pkg::t_res o_res,
    input  logic            i_cfg_valid,
    input  logic            o_cfg_ready,
    input  logic            i_cfg_data,
    output int              o_fail_count,
    output int              o_pending
);
    import sabtb_pkg::*;

    logic [63:0] tag_mem  [SETS*WAYS];
    logic [63:0] tgt_mem  [SETS*WAYS];
    logic [3:0]  type_mem [SETS*WAYS];
    logic [15:0] tree_bits [SETS];
    logic [15:0] lfsr_q;
    logic        evict_rnd;
    t_res        pending_answers [$];
    int          mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic flag_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("MISMATCH at %0t: %s got %h expected %h", $realtime, field, got, want);
        mismatches++;
    endtask

    function automatic int way_of(input int s, input logic [63:0] pc);
        for (int w = 0; w < WAYS; w++) begin
            if (tag_mem[s*WAYS + w] == pc) return w;
        end
        return -1;
    endfunction

    // Walk from the root: a set node bit sends the walk to the lower half
    function automatic int tree_victim(input int s);
        int lo;
        int hi;
        int mid;
        int node;
        lo   = 0;
        hi   = WAYS - 1;
        node = 0;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (tree_bits[s][node]) begin
                hi   = mid;
                node = 2*node + 1;
            end else begin
                lo   = mid + 1;
                node = 2*node + 2;
            end
        end
        return lo;
    endfunction

    // Point the nodes on the way's path away from it
    function automatic void tree_mark_used(input int s, input int way);
        int lo;
        int hi;
        int mid;
        int node;
        lo   = 0;
        hi   = WAYS - 1;
        node = 0;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (way <= mid) begin
                tree_bits[s][node] = 1'b0;
                hi   = mid;
                node = 2*node + 1;
            end else begin
                tree_bits[s][node] = 1'b1;
                lo   = mid + 1;
                node = 2*node + 2;
            end
        end
    endfunction

    function automatic void clear_buffer();
        for (int e = 0; e < SETS*WAYS; e++) begin
            tag_mem[e]  = '0;
            tgt_mem[e]  = '0;
            type_mem[e] = '0;
        end
        for (int s = 0; s < SETS; s++) tree_bits[s] = '0;
    endfunction

    function automatic t_res resolve_branch_cmd(input t_cmd c);
        t_res        ans;
        int          s;
        int          w;
        logic [15:0] nxt;
        ans = '0;
        s   = int'((c.branch_pc >> 1) % SETS);
        case (c.kind)
            KIND_PROBE: begin
                w = way_of(s, c.branch_pc);
                if (w >= 0) begin
                    if (!evict_rnd) tree_mark_used(s, w);
                    ans.hit        = 1'b1;
                    ans.hit_target = tgt_mem[s*WAYS + w];
                    ans.hit_type   = type_mem[s*WAYS + w];
                end
            end
            KIND_ADD: begin
                if (evict_rnd) begin
                    nxt = lfsr_q >> 1;
                    if (lfsr_q[0]) nxt = nxt ^ LFSR_TAPS;
                    lfsr_q = nxt;
                    w = int'(nxt % WAYS);
                end else begin
                    w = tree_victim(s);
                end
                tag_mem[s*WAYS + w]  = c.branch_pc;
                tgt_mem[s*WAYS + w]  = '0;
                type_mem[s*WAYS + w] = c.entry_type;
            end
            KIND_UPDATE: begin
                w = way_of(s, c.branch_pc);
                if (w >= 0) begin
                    tgt_mem[s*WAYS + w]  = c.branch_target;
                    type_mem[s*WAYS + w] = c.entry_type;
                    ans.hit        = 1'b1;
                    ans.hit_target = c.branch_target;
                    ans.hit_type   = c.entry_type;
                end
            end
            default: clear_buffer();
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_buffer();
            lfsr_q    = LFSR_RESET;
            evict_rnd = 1'b0;
            pending_answers.delete();
        end else begin
            // Compare the result first: it always belongs to an earlier transaction
            if (o_res_valid === 1'b1) begin
                if (pending_answers.size() == 0) begin
                    flag_mismatch("unexpected result, hit_target", o_res.hit_target, '0);
                end else begin
                    if (o_res.hit !== pending_answers[0].hit)
                        flag_mismatch("hit", o_res.hit, pending_answers[0].hit);
                    if (o_res.hit_target !== pending_answers[0].hit_target)
                        flag_mismatch("hit_target", o_res.hit_target,
                                      pending_answers[0].hit_target);
                    if (o_res.hit_type !== pending_answers[0].hit_type)
                        flag_mismatch("hit_type", o_res.hit_type,
                                      pending_answers[0].hit_type);
                    void'(pending_answers.pop_front());
                end
            end
            if (i_cfg_valid && o_cfg_ready) evict_rnd = i_cfg_data;
            if (i_start && !o_busy) pending_answers.push_back(resolve_branch_cmd(i_cmd));
        end
        o_pending <= pending_answers.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Top of the branch target buffer testbench: clock, reset, command stimulus and verdict.
// Depends on sabtb_pkg, set_assoc_branch_target_buffer and btb_checker.
module testbench;
    import sabtb_pkg::*;

    localparam int RANDOM_PER_PHASE = 384;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int POOL_SIZE        = 20;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_start     = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic i_cfg_data  = 1'b0;
    t_cmd i_cmd       = '0;
    logic o_busy;
    logic o_res_valid;
    logic o_cfg_ready;
    t_res o_res;
    int   fail_count;
    int   pending;
    int   cycle_cnt   = 0;
    int   no_gap_run  = 0;

    set_assoc_branch_target_buffer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    btb_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_cmd        (i_cmd),
        .o_res_valid  (o_res_valid),
        .o_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Mostly back to back, sometimes short pauses, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_gap_run > 0) begin
            no_gap_run--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            no_gap_run = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [63:0] pc_in_set(input int s);
        logic [63:0] p;
        p = {$urandom, $urandom};
        p[SET_W:1] = SET_W'(s);
        return p;
    endfunction

    task automatic issue(input logic [1:0] kind, input logic [63:0] pc,
                         input logic [63:0] target, input logic [3:0] etype);
        int g;
        i_cmd   <= '{kind: kind, branch_pc: pc, branch_target: target, entry_type: etype};
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        g = pick_gap();
        if (g > 0) begin
            i_start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Drop start, wait for every outstanding result, then idle before going on
    task automatic settle();
        i_start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_evict_mode(input logic rnd);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= rnd;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic directed_checks();
        logic [63:0] set5_pc [5];
        for (int i = 0; i < 5; i++) set5_pc[i] = pc_in_set(5);
        // A cleared entry holds pc 0, so pc 0 hits straight away
        issue(KIND_PROBE, '0, '0, 4'd0);
        issue(KIND_PROBE, '1, '1, 4'd15);
        issue(KIND_UPDATE, '0, '1, 4'd15);
        issue(KIND_PROBE, '0, '0, 4'd0);
        // Five adds into one set of four ways: at least the last must evict
        for (int i = 0; i < 5; i++) issue(KIND_ADD, set5_pc[i], '1, 4'(i * 3));
        for (int i = 0; i < 5; i++) issue(KIND_PROBE, set5_pc[i], '0, 4'd0);
        issue(KIND_UPDATE, set5_pc[4], '0, 4'd0);
        issue(KIND_UPDATE, pc_in_set(5), '1, 4'd15);
        issue(KIND_ADD, '1, '0, 4'd15);
        issue(KIND_PROBE, '1, '0, 4'd0);
        issue(KIND_FLUSH, '0, '0, 4'd0);
        issue(KIND_PROBE, '1, '0, 4'd0);
        issue(KIND_PROBE, '0, '0, 4'd0);
    endtask

    // Pcs crowd a few sets so ways fill and evictions follow; some noise on top
    task automatic random_traffic(input int n);
        logic [63:0] pool [POOL_SIZE];
        logic [63:0] pc;
        logic [1:0]  kind;
        int          r;
        pool[0] = '0;
        for (int i = 1; i < POOL_SIZE; i++) begin
            if ($urandom_range(0, 4) == 0) pool[i] = pc_in_set($urandom_range(0, SETS - 1));
            else                           pool[i] = pc_in_set($urandom_range(0, 3));
        end
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40)      kind = KIND_PROBE;
            else if (r < 68) kind = KIND_ADD;
            else if (r < 98) kind = KIND_UPDATE;
            else             kind = KIND_FLUSH;
            if ($urandom_range(0, 99) < 85) pc = pool[$urandom_range(0, POOL_SIZE - 1)];
            else                            pc = {$urandom, $urandom};
            issue(kind, pc, {$urandom, $urandom}, 4'($urandom_range(0, 15)));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_evict_mode(1'b0);
        directed_checks();
        random_traffic(RANDOM_PER_PHASE);
        settle();
        set_evict_mode(1'b1);
        random_traffic(RANDOM_PER_PHASE);
        settle();
        set_evict_mode(1'b0);
        random_traffic(RANDOM_PER_PHASE);
        settle();
        set_evict_mode(1'b1);
        random_traffic(RANDOM_PER_PHASE);
        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/sabtb_pkg.sv
hw/rtl/sabtb_ram.sv
hw/rtl/sabtb_match.sv
hw/rtl/sabtb_evict.sv
hw/rtl/set_assoc_branch_target_buffer.sv
tb/btb_checker.sv
tb/testbench.sv
